// ----- rtl/spi_mc_pkg.sv -----
// Shared types and constants of the serial register access master.
package spi_mc_pkg;

    localparam int COMMAND_BITS = 8;
    localparam int ADDRESS_BITS = 7;
    localparam int CFG_WIDTH = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP = 2'd1;

    localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET = 16'd3;
    localparam logic [CFG_WIDTH-1:0] GAP_RESET = 16'd10;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] half_period_ticks;
        logic [CFG_WIDTH-1:0] gap_ticks;
    } t_cfg;

endpackage

// ----- rtl/spi_mc_cfg.sv -----
// Configuration registers of the serial register access master.
module spi_mc_cfg (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [spi_mc_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [spi_mc_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    output spi_mc_pkg::t_cfg                       o_cfg
);

    spi_mc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= spi_mc_pkg::HALF_PERIOD_RESET;
            r_cfg.gap_ticks <= spi_mc_pkg::GAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spi_mc_pkg::CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data;
                spi_mc_pkg::CFG_GAP: r_cfg.gap_ticks <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

endmodule

// ----- rtl/spi_mc_engine.sv -----
// Frame sequencer: bus state registers and the next-state and pin logic of one tick.
module spi_mc_engine #(
    parameter int DATA_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_step,
    input  spi_mc_pkg::t_cfg                      i_cfg,
    input  logic                                  i_start_req,
    input  logic                                  i_operation,
    input  logic [spi_mc_pkg::ADDRESS_BITS-1:0]   i_address,
    input  logic [DATA_BITS-1:0]                  i_write_data,
    input  logic                                  i_data_in_pin,
    output logic                                  o_clock_pin,
    output logic                                  o_data_out_pin,
    output logic                                  o_select_n_pin,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic [DATA_BITS-1:0]                  o_read_data
);

    localparam int TOTAL_BITS = spi_mc_pkg::COMMAND_BITS + DATA_BITS;
    localparam int BW = $clog2(TOTAL_BITS + 1);
    localparam int TW = spi_mc_pkg::CFG_WIDTH;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GAP,
        PH_HIGH,
        PH_LOW
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [BW-1:0]         r_bit_count, n_bit_count;
    logic [TW-1:0]         r_tick_count, n_tick_count;
    logic [TOTAL_BITS-1:0] r_out_shift, n_out_shift;
    logic [DATA_BITS-1:0]  r_in_shift, n_in_shift;
    logic                  r_is_write, n_is_write;
    logic                  r_dout, n_dout;

    logic                  rise;
    logic                  done;
    logic [TW-1:0]         half;

    always_comb begin
        half = (i_cfg.half_period_ticks == '0) ? TW'(1) : i_cfg.half_period_ticks;
        n_phase = r_phase;
        n_bit_count = r_bit_count;
        n_tick_count = r_tick_count;
        n_out_shift = r_out_shift;
        n_in_shift = r_in_shift;
        n_is_write = r_is_write;
        n_dout = r_dout;
        rise = 1'b0;
        done = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_is_write = i_operation;
                    n_out_shift = {i_operation, i_address, i_write_data};
                    n_in_shift = '0;
                    n_bit_count = '0;
                    n_dout = 1'b0;
                    if (i_cfg.gap_ticks == '0) begin
                        rise = 1'b1;
                    end else begin
                        n_phase = PH_GAP;
                        n_tick_count = TW'(1);
                    end
                end
            end
            PH_GAP: begin
                if (r_tick_count >= i_cfg.gap_ticks) begin
                    rise = 1'b1;
                end else begin
                    n_tick_count = r_tick_count + TW'(1);
                end
            end
            PH_HIGH: begin
                if (r_tick_count >= half) begin
                    n_phase = PH_LOW;
                    n_tick_count = TW'(1);
                end else begin
                    n_tick_count = r_tick_count + TW'(1);
                end
            end
            PH_LOW: begin
                if (r_tick_count < half) begin
                    n_tick_count = r_tick_count + TW'(1);
                end else if (r_bit_count >= BW'(TOTAL_BITS)) begin
                    done = 1'b1;
                    n_phase = PH_IDLE;
                    n_bit_count = '0;
                    n_tick_count = '0;
                end else if (r_bit_count == BW'(spi_mc_pkg::COMMAND_BITS) && !r_is_write
                             && i_cfg.gap_ticks != '0) begin
                    n_phase = PH_GAP;
                    n_tick_count = TW'(1);
                end else begin
                    rise = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_bit_count = '0;
                n_tick_count = '0;
            end
        endcase

        if (rise) begin
            n_bit_count = n_bit_count + BW'(1);
            n_phase = PH_HIGH;
            n_tick_count = TW'(1);
            if (!n_is_write && n_bit_count > BW'(spi_mc_pkg::COMMAND_BITS)) begin
                n_in_shift = {n_in_shift[DATA_BITS-2:0], i_data_in_pin};
            end else begin
                n_dout = n_out_shift[TOTAL_BITS-1];
                n_out_shift = {n_out_shift[TOTAL_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_clock_pin = (n_phase == PH_HIGH);
    assign o_data_out_pin = (n_phase != PH_IDLE) && n_dout;
    assign o_select_n_pin = (n_phase == PH_IDLE);
    assign o_busy_res = (n_phase != PH_IDLE);
    assign o_done_res = done;
    assign o_read_data = (done && !r_is_write) ? r_in_shift : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit_count <= '0;
            r_tick_count <= '0;
            r_is_write <= 1'b0;
            r_dout <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bit_count <= n_bit_count;
            r_tick_count <= n_tick_count;
            r_is_write <= n_is_write;
            r_dout <= n_dout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_out_shift <= n_out_shift;
            r_in_shift <= n_in_shift;
        end
    end

endmodule

// ----- rtl/spi_master_32bit_register_access_unit.sv -----
// Top level of the serial register access master: handshakes and result register.
//
// Each input item is one time tick of the serial bus master; the block takes one item in
// every clock cycle while o_stall is low and returns exactly one result item per item,
// holding the pin levels, busy and done after that tick. The result appears in the output
// register on the cycle after the item is accepted; that output register alone sets the
// delay, as the frame sequencer drives pins, busy and done from its next state. A new item
// is accepted while a result waits, as long as the result is taken in the same cycle.
module spi_master_32bit_register_access_unit #(
    parameter int DATA_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [spi_mc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [spi_mc_pkg::CFG_WIDTH-1:0]      i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_start_req,
    input  logic                                  i_operation,
    input  logic [spi_mc_pkg::ADDRESS_BITS-1:0]   i_address,
    input  logic [DATA_BITS-1:0]                  i_write_data,
    input  logic                                  i_data_in_pin,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_clock_pin,
    output logic                                  o_data_out_pin,
    output logic                                  o_select_n_pin,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic [DATA_BITS-1:0]                  o_read_data
);

    spi_mc_pkg::t_cfg     cfg;
    logic                 in_accept;
    logic                 out_take;
    logic                 clock_pin, data_out_pin, select_n_pin, busy, done;
    logic [DATA_BITS-1:0] read_data;

    logic                 r_valid, n_valid;
    logic                 r_clock_pin, r_data_out_pin, r_select_n_pin, r_busy, r_done;
    logic [DATA_BITS-1:0] r_read_data;

    spi_mc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    spi_mc_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_accept),
        .i_cfg          (cfg),
        .i_start_req    (i_start_req),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_data_in_pin  (i_data_in_pin),
        .o_clock_pin    (clock_pin),
        .o_data_out_pin (data_out_pin),
        .o_select_n_pin (select_n_pin),
        .o_busy_res     (busy),
        .o_done_res     (done),
        .o_read_data    (read_data)
    );

    assign o_stall = r_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign out_take = r_valid && !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (in_accept) begin
            n_valid = 1'b1;
        end else if (out_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_clock_pin <= clock_pin;
            r_data_out_pin <= data_out_pin;
            r_select_n_pin <= select_n_pin;
            r_busy <= busy;
            r_done <= done;
            r_read_data <= read_data;
        end
    end

    assign o_valid = r_valid;
    assign o_clock_pin = r_clock_pin;
    assign o_data_out_pin = r_data_out_pin;
    assign o_select_n_pin = r_select_n_pin;
    assign o_busy_res = r_busy;
    assign o_done_res = r_done;
    assign o_read_data = r_read_data;

endmodule
